### rtl/ptrlr_pkg.sv
// ----------------------------------------------------------------------------
// ptrlr_pkg
// Shared types and constants for the page-to-row LCD refresh block.
// ----------------------------------------------------------------------------
package ptrlr_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_ROW   = 2'd1;
	localparam logic [1:0] OP_INIT  = 2'd2;

	// command queue between front and back
	localparam int CQ_DEPTH = 2;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

	// result queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// frame store: one word holds 8 adjacent column bytes of a page
	localparam int MEM_WORDS = 128;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int MEM_DW    = 64;

	localparam int ROW_XFERS  = 18;
	localparam int INIT_XFERS = 5;
	localparam int XFER_IDX_W = 5;

	localparam logic [7:0] CMD_ADDR  = 8'h80;
	localparam logic [7:0] HADDR_LOW = 8'h08;

	typedef struct packed {
		logic [1:0] op;
		logic [9:0] byte_addr;
		logic [7:0] byte_value;
		logic [5:0] row;
	} cmd_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       is_data;
		logic       last;
	} res_t;

	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h30;
			3'd1:    b = 8'h36;
			3'd2:    b = 8'h0C;
			3'd3:    b = 8'h01;
			3'd4:    b = 8'h06;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

### rtl/ptrlr_front.sv
// ----------------------------------------------------------------------------
// ptrlr_front
// Input side: accepts requests, drops unused op codes, queues the rest.
// ----------------------------------------------------------------------------
module ptrlr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  ptrlr_pkg::cmd_t  in_cmd,
	output logic             cq_valid,
	output ptrlr_pkg::cmd_t  cq_head,
	input  logic             cq_pop
);
	import ptrlr_pkg::*;

	cmd_t             cq_mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_CW-1:0] cnt_q;
	logic             accept;
	logic             keep;

	assign full     = (cnt_q == CQ_CW'(CQ_DEPTH));
	assign accept   = push && !full;
	// op 3 is accepted and discarded
	assign keep     = accept && (in_cmd.op == OP_WRITE || in_cmd.op == OP_ROW ||
		in_cmd.op == OP_INIT);
	assign cq_valid = (cnt_q != '0);
	assign cq_head  = cq_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (keep) begin
			cq_mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (keep) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cq_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CQ_CW'(keep) - CQ_CW'(cq_pop);
		end
	end

endmodule

### rtl/ptrlr_outq.sv
// ----------------------------------------------------------------------------
// ptrlr_outq
// Result queue; exposes its fill count so the back end issues on credit.
// ----------------------------------------------------------------------------
module ptrlr_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_push,
	input  ptrlr_pkg::res_t              in_data,
	output logic [ptrlr_pkg::OQ_CW-1:0]  count,
	output logic                         empty,
	input  logic                         pop,
	output ptrlr_pkg::res_t              head
);
	import ptrlr_pkg::*;

	res_t             mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             do_pop;

	assign count  = cnt_q;
	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign head   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (in_push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (in_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + OQ_CW'(in_push) - OQ_CW'(do_pop);
		end
	end

endmodule

### rtl/ptrlr_back.sv
// ----------------------------------------------------------------------------
// ptrlr_back
// Execution side: owns the frame store, performs byte writes and sequences
// row and init transfers into the result queue.
// ----------------------------------------------------------------------------
module ptrlr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cq_valid,
	input  ptrlr_pkg::cmd_t              cq_head,
	output logic                         cq_pop,
	input  logic [ptrlr_pkg::OQ_CW-1:0]  oq_count,
	output logic                         oq_push,
	output ptrlr_pkg::res_t              oq_data
);
	import ptrlr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ROW  = 3'b010,
		ST_INIT = 3'b100
	} state_t;

	state_t                state_q;
	logic [XFER_IDX_W-1:0] idx_q;
	logic [5:0]            row_q;

	logic [MEM_DW-1:0]     mem [MEM_WORDS];
	logic [MEM_WORDS-1:0]  vld_q;

	logic                  v_s1;
	logic                  data_s1;
	logic                  last_s1;
	logic [7:0]            cmd_s1;
	logic [2:0]            sel_s1;
	logic [MEM_DW-1:0]     rd_word_s1;
	logic                  rd_vld_s1;

	logic [OQ_CW:0]        used;
	logic                  can_issue;
	logic                  issue;
	logic [XFER_IDX_W-1:0] final_idx;
	logic [XFER_IDX_W-1:0] kfull;
	logic [MEM_AW-1:0]     rd_addr;
	logic [7:0]            cmd_n;
	logic                  data_n;
	logic                  wr_en;
	logic [MEM_AW-1:0]     widx;
	logic [2:0]            lane;
	logic [7:0]            acc;

	assign cq_pop    = (state_q == ST_IDLE) && cq_valid;
	assign wr_en     = cq_pop && (cq_head.op == OP_WRITE);
	assign widx      = cq_head.byte_addr[9:3];
	assign lane      = cq_head.byte_addr[2:0];

	// credit: queued results plus the one in flight must leave a free slot
	assign used      = {1'b0, oq_count} + (OQ_CW+1)'(v_s1);
	assign can_issue = used < (OQ_CW+1)'(OQ_DEPTH);
	assign issue     = (state_q != ST_IDLE) && can_issue;
	assign final_idx = (state_q == ST_ROW) ? XFER_IDX_W'(ROW_XFERS - 1) :
		XFER_IDX_W'(INIT_XFERS - 1);
	assign kfull     = idx_q - XFER_IDX_W'(2);
	assign rd_addr   = {row_q[5:3], kfull[3:0]};
	assign data_n    = (state_q == ST_ROW) && (idx_q >= XFER_IDX_W'(2));

	always_comb begin
		if (state_q == ST_INIT) begin
			cmd_n = init_cmd(idx_q[2:0]);
		end else if (idx_q == '0) begin
			cmd_n = CMD_ADDR | {3'b000, row_q[4:0]};
		end else begin
			cmd_n = CMD_ADDR | (row_q[5] ? HADDR_LOW : 8'h00);
		end
	end

	// gather the selected bit of 8 column bytes; leftmost column to the MSB
	always_comb begin
		acc = '0;
		for (int c = 0; c < 8; c++) begin
			acc[7-c] = rd_vld_s1 & rd_word_s1[6'(c * 8) + {3'b000, sel_s1}];
		end
	end

	assign oq_push          = v_s1;
	assign oq_data.bus_byte = data_s1 ? acc : cmd_s1;
	assign oq_data.is_data  = data_s1;
	assign oq_data.last     = last_s1;

	// a word never written is filled with zeros on its first byte write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (vld_q[widx]) begin
				mem[widx][{lane, 3'b000} +: 8] <= cq_head.byte_value;
			end else begin
				mem[widx] <= MEM_DW'(cq_head.byte_value) << {lane, 3'b000};
			end
		end
		if (issue) begin
			rd_word_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_vld_s1 <= vld_q[rd_addr];
			data_s1   <= data_n;
			last_s1   <= (idx_q == final_idx);
			cmd_s1    <= cmd_n;
			sel_s1    <= row_q[2:0];
		end
		if (cq_pop) begin
			row_q <= cq_head.row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			vld_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (wr_en) begin
				vld_q[widx] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (cq_pop) begin
						if (cq_head.op == OP_ROW) begin
							state_q <= ST_ROW;
						end else if (cq_head.op == OP_INIT) begin
							state_q <= ST_INIT;
						end
					end
				end
				ST_ROW, ST_INIT: begin
					if (issue) begin
						if (idx_q == final_idx) begin
							state_q <= ST_IDLE;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/page_to_row_lcd_refresh.sv
// ----------------------------------------------------------------------------
// page_to_row_lcd_refresh
// 128x64 page-layout frame store with row-order refresh transfers for a
// graphic LCD controller.
//
//   channel  | handshake        | fields
//   ---------+------------------+------------------------------------
//   request  | push / full      | op, byte_addr, byte_value, row
//   transfer | empty / pop      | bus_byte, is_data, last
//
// Back end work per request: a frame write ends with its dequeue; init
// and row requests are dequeued, then send one transfer per cycle while
// the transfer queue has credit, paced by the single frame-store read
// port. A 2-entry request queue keeps the front accepting while the back
// end runs. Reset clears the per-word valid bits of the frame store, so
// the screen reads blank at once. A stalled pop holds the back end once
// the 4-entry transfer queue has no credit.
// ----------------------------------------------------------------------------
module page_to_row_lcd_refresh (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] op,
	input  logic [9:0] byte_addr,
	input  logic [7:0] byte_value,
	input  logic [5:0] row,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] bus_byte,
	output logic       is_data,
	output logic       last
);
	import ptrlr_pkg::*;

	cmd_t             in_cmd;
	cmd_t             cq_head;
	logic             cq_valid;
	logic             cq_pop;
	logic [OQ_CW-1:0] oq_count;
	logic             oq_push;
	res_t             oq_data;
	res_t             head;

	assign in_cmd.op         = op;
	assign in_cmd.byte_addr  = byte_addr;
	assign in_cmd.byte_value = byte_value;
	assign in_cmd.row        = row;

	ptrlr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_cmd   (in_cmd),
		.cq_valid (cq_valid),
		.cq_head  (cq_head),
		.cq_pop   (cq_pop)
	);

	ptrlr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_valid (cq_valid),
		.cq_head  (cq_head),
		.cq_pop   (cq_pop),
		.oq_count (oq_count),
		.oq_push  (oq_push),
		.oq_data  (oq_data)
	);

	ptrlr_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_push (oq_push),
		.in_data (oq_data),
		.count   (oq_count),
		.empty   (empty),
		.pop     (pop),
		.head    (head)
	);

	assign bus_byte = head.bus_byte;
	assign is_data  = head.is_data;
	assign last     = head.last;

endmodule

### rtl/ptrlr_checker.sv
// ----------------------------------------------------------------------------
// ptrlr_checker
// Port-level checks on the transfer side of the refresh block.
// ----------------------------------------------------------------------------
module ptrlr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] bus_byte,
	input logic       is_data,
	input logic       last
);

	// a waiting transaction stays until popped
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("transfer dropped without pop");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(bus_byte) && $stable(is_data) && $stable(last)))
		else $error("stalled transfer changed");

	// address commands never end a sequence
	a_addr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_data && bus_byte[7]) |-> !last)
		else $error("address command flagged last");

	// other commands are init commands; the init sequence ends on 0x06
	a_init_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_data && !bus_byte[7]) |->
		((bus_byte == 8'h30 || bus_byte == 8'h36 || bus_byte == 8'h0C ||
		bus_byte == 8'h01 || bus_byte == 8'h06) && (last == (bus_byte == 8'h06))))
		else $error("bad init command");

endmodule

bind page_to_row_lcd_refresh ptrlr_checker u_chk (.*);
